// ===== hw/rtl/ssort_pkg.sv =====
// ----------------------------------------------------------------------------
// Stable ascending sorter package
// Shared constants, the link that travels along the chain of cells and the command broadcast to them.
// ----------------------------------------------------------------------------
package ssort_pkg;

	localparam int SSORT_MAX_ITEMS_DEF = 64;
	localparam int SSORT_VALUE_W       = 32;

	// Contents of one cell as seen by its neighbors.
	typedef struct packed {
		logic signed [SSORT_VALUE_W-1:0] val;
		logic                            valid;
		logic                            gt;
	} ssort_link_t;

	// Command broadcast to every cell in a cycle.
	typedef struct packed {
		logic                            ins;
		logic                            shift;
		logic signed [SSORT_VALUE_W-1:0] v;
	} ssort_ctrl_t;

endpackage

// ===== hw/rtl/ssort_cell.sv =====
// ----------------------------------------------------------------------------
// Stable ascending sorter cell
// Holds one element of the sorted list; inserts, shifts right on insertion
// and shifts left during emission.
// ----------------------------------------------------------------------------
module ssort_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  ssort_pkg::ssort_ctrl_t ctrl,
	input  ssort_pkg::ssort_link_t left,
	input  ssort_pkg::ssort_link_t right,
	output ssort_pkg::ssort_link_t link
);
	import ssort_pkg::*;

	logic signed [SSORT_VALUE_W-1:0] val_q;
	logic                            valid_q;
	logic                            gt;

	// Strictly greater keeps equal keys in arrival order.
	assign gt = valid_q && (val_q > ctrl.v);

	assign link.val   = val_q;
	assign link.valid = valid_q;
	assign link.gt    = gt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.shift) begin
			valid_q <= right.valid;
		end else if (ctrl.ins) begin
			valid_q <= valid_q || left.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			val_q <= right.val;
		end else if (ctrl.ins) begin
			if (left.gt) begin
				val_q <= left.val;
			end else if (gt || (!valid_q && left.valid)) begin
				val_q <= ctrl.v;
			end
		end
	end

endmodule

// ===== hw/rtl/stable_ascending_sorter_unit.sv =====
// ----------------------------------------------------------------------------
// Stable ascending sorter unit
// Collects a list of signed 32-bit values and emits it sorted, stable order.
// ----------------------------------------------------------------------------
// Usage: a transaction is presented on value and last with start high; it is
// taken at a rising edge where start is high and busy is low. While loading,
// busy stays low, so one element is taken every cycle: a row of MAX_ITEMS
// cells keeps the list sorted, and each new element goes straight into its place.
// An element that finds the row full is dropped and the list is marked as
// overflowed.
// When the element with last set is taken, busy rises in the next cycle and
// the list streams out of the head cell, one result per cycle, with strobe
// high for each. The first result comes as busy rises, and a list of n
// stored elements gives n results. last_res marks the final result and
// overflow is the same on every result of the list. The receiver cannot
// stall: each result is valid for exactly one cycle.
// After the final result the row is empty and busy falls the next cycle.
// Reset empties the row and clears the overflow mark; no clearing pass.
// ----------------------------------------------------------------------------
module stable_ascending_sorter_unit #(
	parameter int MAX_ITEMS = ssort_pkg::SSORT_MAX_ITEMS_DEF
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      start,
	output logic                                      busy,
	input  logic signed [ssort_pkg::SSORT_VALUE_W-1:0] value,
	input  logic                                      last,
	output logic                                      strobe,
	output logic signed [ssort_pkg::SSORT_VALUE_W-1:0] value_res,
	output logic                                      last_res,
	output logic                                      overflow
);
	import ssort_pkg::*;

	ssort_link_t link [MAX_ITEMS];
	ssort_link_t head_link;
	ssort_link_t tail_link;
	ssort_ctrl_t ctrl;

	logic emit_q;
	logic overflow_q;
	logic accept;
	logic full;

	// The head sees an always-valid, never-greater neighbor so that an empty
	// row takes the first element into cell zero. The tail feeds empties.
	assign head_link = '{val: '0, valid: 1'b1, gt: 1'b0};
	assign tail_link = '{val: '0, valid: 1'b0, gt: 1'b0};

	assign accept = start && !busy;
	assign full   = link[MAX_ITEMS-1].valid;

	assign ctrl.ins   = accept && !full;
	assign ctrl.shift = emit_q;
	assign ctrl.v     = value;

	genvar gi;
	generate
		for (gi = 0; gi < MAX_ITEMS; gi++) begin : g_cell
			ssort_link_t left_in;
			ssort_link_t right_in;
			if (gi == 0) begin : g_head
				assign left_in = head_link;
			end else begin : g_mid_l
				assign left_in = link[gi-1];
			end
			if (gi == MAX_ITEMS-1) begin : g_tail
				assign right_in = tail_link;
			end else begin : g_mid_r
				assign right_in = link[gi+1];
			end
			ssort_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.ctrl   (ctrl),
				.left   (left_in),
				.right  (right_in),
				.link   (link[gi])
			);
		end
	endgenerate

	// Emission runs from the cycle after the final element until the head
	// cell hands out the last stored element.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_q     <= 1'b0;
			overflow_q <= 1'b0;
		end else if (emit_q) begin
			if (!link[1].valid) begin
				emit_q     <= 1'b0;
				overflow_q <= 1'b0;
			end
		end else if (accept) begin
			if (full) begin
				overflow_q <= 1'b1;
			end
			if (last) begin
				emit_q <= 1'b1;
			end
		end
	end

	assign busy      = emit_q;
	assign strobe    = emit_q;
	assign value_res = link[0].val;
	assign last_res  = !link[1].valid;
	assign overflow  = overflow_q;

	// A result that is not final is followed by another in the next cycle.
	a_burst_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last_res |=> strobe)
		else $error("emission stopped before the final result");

	// The final result frees the block in the next cycle.
	a_final_frees: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last_res |=> !busy)
		else $error("busy held after final result");

	// Emission only starts after a final element was taken.
	a_emit_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start && last))
		else $error("emission without a final element");

	// The head cell holds an element throughout emission.
	a_head_valid: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> link[0].valid)
		else $error("empty head cell during emission");

	// The overflow mark cannot change in the middle of a list's emission.
	a_ovf_steady: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last_res |=> $stable(overflow))
		else $error("overflow flag changed during emission");

endmodule

// ===== tb/sv/stable_ascending_sorter_checker.sv =====
// ----------------------------------------------------------------------------
// Stable ascending sorter checker
// Watches the input and result channels of the sorter. It keeps its own copy
// of the collected list, works out the sorted list when the final element is
// taken, and compares every result against the oldest expected one.
// ----------------------------------------------------------------------------
module stable_ascending_sorter_checker #(
	parameter int MAX_ITEMS = ssort_pkg::SSORT_MAX_ITEMS_DEF
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       start,
	input  logic                                       busy,
	input  logic signed [ssort_pkg::SSORT_VALUE_W-1:0] value,
	input  logic                                       last,
	input  logic                                       strobe,
	input  logic signed [ssort_pkg::SSORT_VALUE_W-1:0] value_res,
	input  logic                                       last_res,
	input  logic                                       overflow,
	output int                                         mismatch_count,
	output int                                         results_owed
);

	localparam int W = ssort_pkg::SSORT_VALUE_W;

	typedef struct {
		logic signed [W-1:0] value;
		logic                last;
		logic                overflow;
	} sorted_elem_t;

	logic signed [W-1:0] held_list [MAX_ITEMS];
	int                  held_count;
	logic                dropped_any;
	sorted_elem_t        sorted_results_q [$];

	// Insertion sort with a strict compare, so equal keys keep arrival order.
	function automatic void queue_sorted_list();
		logic signed [W-1:0] work [MAX_ITEMS];
		logic signed [W-1:0] key;
		sorted_elem_t        elem;
		int                  i;
		int                  j;
		work = held_list;
		for (i = 1; i < held_count; i++) begin
			key = work[i];
			j = i;
			while (j > 0 && work[j-1] > key) begin
				work[j] = work[j-1];
				j--;
			end
			work[j] = key;
		end
		for (i = 0; i < held_count; i++) begin
			elem.value    = work[i];
			elem.last     = (i == held_count - 1);
			elem.overflow = dropped_any;
			sorted_results_q.push_back(elem);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		int           errs;
		sorted_elem_t exp_elem;
		errs = 0;
		if (!arst_n) begin
			held_count  = 0;
			dropped_any = 1'b0;
			sorted_results_q.delete();
			results_owed   <= 0;
			mismatch_count <= 0;
		end else begin
			if (strobe) begin
				if (sorted_results_q.size() == 0) begin
					$error("unexpected result: value_res=%0d last_res=%0b overflow=%0b",
						value_res, last_res, overflow);
					errs++;
				end else begin
					exp_elem = sorted_results_q.pop_front();
					if (value_res !== exp_elem.value) begin
						$error("value_res: expected %0d, actual %0d", exp_elem.value, value_res);
						errs++;
					end
					if (last_res !== exp_elem.last) begin
						$error("last_res: expected %0b, actual %0b", exp_elem.last, last_res);
						errs++;
					end
					if (overflow !== exp_elem.overflow) begin
						$error("overflow: expected %0b, actual %0b", exp_elem.overflow, overflow);
						errs++;
					end
				end
			end
			if (start && !busy) begin
				if (held_count < MAX_ITEMS) begin
					held_list[held_count] = value;
					held_count++;
				end else begin
					dropped_any = 1'b1;
				end
				if (last) begin
					queue_sorted_list();
					held_count  = 0;
					dropped_any = 1'b0;
				end
			end
			results_owed   <= sorted_results_q.size();
			mismatch_count <= mismatch_count + errs;
		end
	end

endmodule

// ===== tb/sv/tb_stable_ascending_sorter_unit.sv =====
// ----------------------------------------------------------------------------
// Stable ascending sorter unit testbench
// Sends lists of signed values through the sorter, first a few directed lists
// with extreme values and ties, then random lists of mostly short length
// with a few that fill or overflow the row. A checker beside the block
// predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_stable_ascending_sorter_unit;

	import ssort_pkg::*;

	localparam int W            = SSORT_VALUE_W;
	localparam int MAX_ITEMS    = SSORT_MAX_ITEMS_DEF;
	localparam int RANDOM_ITEMS = 500;

	logic                clk;
	logic                arst_n;
	logic                start;
	logic                busy;
	logic signed [W-1:0] value;
	logic                last;
	logic                strobe;
	logic signed [W-1:0] value_res;
	logic                last_res;
	logic                overflow;
	int                  mismatch_count;
	int                  results_owed;

	stable_ascending_sorter_unit #(
		.MAX_ITEMS(MAX_ITEMS)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.value    (value),
		.last     (last),
		.strobe   (strobe),
		.value_res(value_res),
		.last_res (last_res),
		.overflow (overflow)
	);

	// The checker sees the same pins as the block and reports how many
	// mismatches it found and how many results it is still waiting for.
	stable_ascending_sorter_checker #(
		.MAX_ITEMS(MAX_ITEMS)
	) u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.value         (value),
		.last          (last),
		.strobe        (strobe),
		.value_res     (value_res),
		.last_res      (last_res),
		.overflow      (overflow),
		.mismatch_count(mismatch_count),
		.results_owed  (results_owed)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Offers one element and returns at the edge where the block takes the
	// transaction. Before the offer the sender idles with start low, each
	// cycle with the given odds in a hundred. start is left high afterward,
	// so back-to-back elements keep it high without a glitch; the next call
	// or the end drops it.
	task automatic push_element(input logic signed [W-1:0] v, input logic is_last,
		input int idle_pct);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		value <= v;
		last  <= is_last;
		// The transaction is taken at the first edge that sees busy low.
		do @(posedge clk); while (busy);
	endtask

	// A mix of fully random words, a narrow band around zero that makes many
	// ties, and the words at both ends of the signed range.
	function automatic logic signed [W-1:0] pick_value();
		int band;
		case ($urandom_range(3))
			0, 1: pick_value = $urandom;
			2: begin
				band = $urandom_range(8);
				pick_value = band - 4;
			end
			default: begin
				case ($urandom_range(5))
					0: pick_value = 32'sh8000_0000;
					1: pick_value = 32'sh8000_0001;
					2: pick_value = 32'sh7fff_ffff;
					3: pick_value = 32'sh7fff_fffe;
					4: pick_value = 0;
					default: pick_value = -1;
				endcase
			end
		endcase
	endfunction

	initial begin
		logic signed [W-1:0] mixed_list [8];
		int                  sent;
		int                  list_idx;
		int                  list_len;
		int                  idle_pct;
		int                  k;
		int                  drain_cycles;

		mixed_list = '{32'sd5, -32'sd3, 32'sd0, -32'sd3,
			32'sh7fff_ffff, 32'sh8000_0000, -32'sd1, 32'sd1};

		arst_n = 1'b0;
		start  = 1'b0;
		value  = '0;
		last   = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed lists. A list of one element at each end of the range.
		push_element(32'sh8000_0000, 1'b1, 16);
		push_element(32'sh7fff_ffff, 1'b1, 16);
		// Both extremes, ties and every sign in one list.
		for (k = 0; k < 8; k++)
			push_element(mixed_list[k], k == 7, 16);
		// All keys equal; the stable order must hold them in place.
		for (k = 0; k < 3; k++)
			push_element(32'sd0, k == 2, 16);
		// Strictly descending, so each new element goes to the head of the row.
		for (k = 3; k > 0; k--)
			push_element(k, k == 1, 16);

		// Random lists. The first third of the items comes with light sender
		// idling, the second with heavy idling, the last with none. Two lists
		// are forced to fill the row exactly and to overflow it, the latter
		// with the final element dropped as well; a few more land near the
		// row size by chance. The rest are short.
		sent     = 0;
		list_idx = 0;
		while (sent < RANDOM_ITEMS) begin
			list_idx++;
			if (list_idx == 3)
				list_len = MAX_ITEMS;
			else if (list_idx == 7)
				list_len = MAX_ITEMS + 3;
			else if ($urandom_range(19) == 0)
				list_len = $urandom_range(MAX_ITEMS - 2, MAX_ITEMS + 6);
			else
				list_len = $urandom_range(1, 12);
			if (sent < RANDOM_ITEMS / 3)
				idle_pct = 16;
			else if (sent < 2 * RANDOM_ITEMS / 3)
				idle_pct = 57;
			else
				idle_pct = 0;
			for (k = 0; k < list_len; k++)
				push_element(pick_value(), k == list_len - 1, idle_pct);
			sent += list_len;
		end
		start <= 1'b0;

		// Wait for the last list to stream out, then keep the clock running so
		// that any stray result would still be seen by the checker.
		drain_cycles = 0;
		do begin
			@(posedge clk);
			drain_cycles++;
		end while (results_owed != 0 && drain_cycles < 4 * MAX_ITEMS + 100);
		repeat (MAX_ITEMS + 8) @(posedge clk);

		if (mismatch_count == 0 && results_owed == 0) begin
			$display("tb_stable_ascending_sorter_unit: PASS");
		end else begin
			$display("tb_stable_ascending_sorter_unit: FAIL");
		end
		$finish;
	end

	// Watchdog: a run that has not finished by this time ends as a failure.
	initial begin
		#2000000;
		$display("tb_stable_ascending_sorter_unit: FAIL");
		$finish;
	end

endmodule
